// File: rtl/masked_column_post_blitter_defines.svh
// ----------------------------------------------------------------------------
// masked_column_post_blitter_defines.svh
// assertion macros shared by the masked column post blitter rtl
// ----------------------------------------------------------------------------
`ifndef MASKED_COLUMN_POST_BLITTER_DEFINES_SVH
`define MASKED_COLUMN_POST_BLITTER_DEFINES_SVH

`ifndef ASSERT_OFF

// property must hold at every clock edge outside reset
`define MCPB_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// expression must never be true outside reset
`define MCPB_ASSERT_NEVER(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`else

`define MCPB_ASSERT(label, clk, rst_n, prop, msg)
`define MCPB_ASSERT_NEVER(label, clk, rst_n, expr, msg)

`endif

`endif

// File: rtl/mcpb_pkg.sv
// ----------------------------------------------------------------------------
// mcpb_pkg
// screen geometry, parse phases, stream codes and register indexes
// ----------------------------------------------------------------------------
package mcpb_pkg;

    localparam int SCREEN_WIDTH  = 320;
    localparam int SCREEN_HEIGHT = 200;

    localparam int TABLE_DEPTH = 256;
    localparam int PIXEL_W     = 8;
    localparam int ADDR_W      = 16;
    localparam int COORD_W     = 16;
    localparam int SIZE_W      = 12;
    localparam int POS_W       = 19;
    localparam int PROD_W      = 32;

    localparam logic [7:0] END_OF_COLUMN = 8'hFF;

    // input item modes
    localparam logic [1:0] MODE_START = 2'd0;
    localparam logic [1:0] MODE_BYTE  = 2'd1;
    localparam logic [1:0] MODE_LOAD  = 2'd2;

    // configuration register indexes
    localparam int CFG_IDX_W = 8;
    localparam logic [CFG_IDX_W-1:0] CFG_DRAW_X      = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DRAW_Y      = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LEFT_OFFSET = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TOP_OFFSET  = 8'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_PIC_WIDTH   = 8'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_PIC_HEIGHT  = 8'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_FLIP        = 8'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_TRANSLATE   = 8'd7;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_TOP,
        PH_LEN,
        PH_PAD1,
        PH_PIX,
        PH_PAD2
    } phase_t;

    // one decoded item on its way to the output register
    typedef struct packed {
        logic                  err;
        logic                  use_tbl;
        logic [COORD_W-1:0]    row;
        logic [COORD_W-1:0]    col;
        logic [PIXEL_W-1:0]    raw;
    } draw_t;

endpackage

// File: rtl/mcpb_ram.sv
// ----------------------------------------------------------------------------
// mcpb_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
module mcpb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/masked_column_post_blitter.sv
// ----------------------------------------------------------------------------
// masked_column_post_blitter
// decodes masked picture column streams into framebuffer pixel writes
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake              payload
//  s_        in         s_valid / s_ready      mode, column_index, byte_value, table_index
//  m_        out        m_valid / m_ready      fb_address, pixel, placement_error
//  cfg_      in         cfg_valid / cfg_ready  cfg_index, cfg_data
//
//  one item a cycle while s_ready is high; a pixel result passes the decode stage register,
//  where the colour table read data is also registered, and then the output register
//  the colour table is a 256 by 8 ram read once per drawn pixel item, written by load items
//  aresetn (synchronous) returns to idle with valid, parse and configuration registers zero, the table is not cleared
//  a stalled result holds the output register and the decode stage, and s_ready
//  drops only when both are full
//  cfg_ready is always high
//
module masked_column_post_blitter (
    input  logic                            aclk,
    input  logic                            aresetn,

    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [1:0]                      s_mode,
    input  logic [mcpb_pkg::SIZE_W-1:0]     s_column_index,
    input  logic [7:0]                      s_byte_value,
    input  logic [7:0]                      s_table_index,

    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [mcpb_pkg::ADDR_W-1:0]     m_fb_address,
    output logic [mcpb_pkg::PIXEL_W-1:0]    m_pixel,
    output logic                            m_placement_error,

    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [mcpb_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [mcpb_pkg::COORD_W-1:0]    cfg_data
);

    import mcpb_pkg::*;

`include "masked_column_post_blitter_defines.svh"

    localparam logic signed [POS_W-1:0] SW_S = POS_W'(SCREEN_WIDTH);
    localparam logic signed [POS_W-1:0] SH_S = POS_W'(SCREEN_HEIGHT);
    localparam logic [COORD_W-1:0]      SH_U = COORD_W'(SCREEN_HEIGHT);

    // configuration registers
    logic [COORD_W-1:0] draw_x_reg, draw_y_reg, left_offset_reg, top_offset_reg;
    logic [SIZE_W-1:0]  pic_width_reg, pic_height_reg;
    logic               flip_reg, translate_reg;

    // column parse state
    phase_t             phase_reg, phase_next;
    logic [7:0]         pixels_left_reg, pixels_left_next;
    logic [COORD_W-1:0] current_row_reg, current_row_next;
    logic [COORD_W-1:0] screen_col_reg, screen_col_next;
    logic [COORD_W-1:0] column_top_reg, column_top_next;
    logic               blocked_reg, blocked_next;
    logic               col_flip_reg, col_flip_next;
    logic               col_trans_reg, col_trans_next;

    // decode stage and output register
    logic               s1_valid_reg;
    draw_t              s1_reg, s1_next;
    logic               emit;
    logic               s1_adv;
    logic               s_accept;

    logic               m_valid_reg;
    logic [ADDR_W-1:0]  m_addr_reg;
    logic [PIXEL_W-1:0] m_pixel_reg;
    logic               m_err_reg;

    // placement arithmetic
    logic signed [POS_W-1:0] pos_x, pos_y, pic_w, pic_h, col_pos, flip_pos;
    logic                    place_bad;

    // table access
    logic               tbl_we, tbl_re;
    logic [PIXEL_W-1:0] tbl_rdata;

    logic [PROD_W-1:0]  addr_full;

    // ------------------------------------------------------------------
    // handshakes
    // ------------------------------------------------------------------
    assign cfg_ready = 1'b1;
    assign s1_adv    = !m_valid_reg || m_ready;
    assign s_ready   = !s1_valid_reg || s1_adv;
    assign s_accept  = s_valid && s_ready;

    // ------------------------------------------------------------------
    // configuration writes
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            draw_x_reg      <= '0;
            draw_y_reg      <= '0;
            left_offset_reg <= '0;
            top_offset_reg  <= '0;
            pic_width_reg   <= '0;
            pic_height_reg  <= '0;
            flip_reg        <= 1'b0;
            translate_reg   <= 1'b0;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_DRAW_X:      draw_x_reg      <= cfg_data;
                CFG_DRAW_Y:      draw_y_reg      <= cfg_data;
                CFG_LEFT_OFFSET: left_offset_reg <= cfg_data;
                CFG_TOP_OFFSET:  top_offset_reg  <= cfg_data;
                CFG_PIC_WIDTH:   pic_width_reg   <= cfg_data[SIZE_W-1:0];
                CFG_PIC_HEIGHT:  pic_height_reg  <= cfg_data[SIZE_W-1:0];
                CFG_FLIP:        flip_reg        <= cfg_data[0];
                CFG_TRANSLATE:   translate_reg   <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // placement of a new column
    // ------------------------------------------------------------------
    always_comb begin
        pos_x = POS_W'($signed(draw_x_reg)) - POS_W'($signed(left_offset_reg));
        pos_y = POS_W'($signed(draw_y_reg)) - POS_W'($signed(top_offset_reg));
        pic_w = POS_W'(pic_width_reg);
        pic_h = POS_W'(pic_height_reg);
        col_pos  = pos_x + POS_W'(s_column_index);
        // mirrored column, only used when the column lies inside the picture
        flip_pos = pos_x + pic_w - POS_W'(1) - POS_W'(s_column_index);
        place_bad = (pos_x < 0) || (pos_x + pic_w > SW_S) || (pos_y < 0) ||
                    (pos_y + pic_h > SH_S) || (s_column_index >= pic_width_reg);
    end

    // ------------------------------------------------------------------
    // parse phase, next state
    // ------------------------------------------------------------------
    always_comb begin
        phase_next = phase_reg;
        if (s_accept) begin
            if (s_mode == MODE_START) begin
                phase_next = PH_TOP;
            end else if (s_mode == MODE_BYTE) begin
                unique case (phase_reg)
                    PH_TOP:  phase_next = (s_byte_value == END_OF_COLUMN) ? PH_IDLE : PH_LEN;
                    PH_LEN:  phase_next = PH_PAD1;
                    PH_PAD1: phase_next = (pixels_left_reg != '0) ? PH_PIX : PH_PAD2;
                    PH_PIX:  phase_next = (pixels_left_reg == 8'd1) ? PH_PAD2 : PH_PIX;
                    PH_PAD2: phase_next = PH_TOP;
                    default: phase_next = phase_reg;
                endcase
            end
        end
    end

    // ------------------------------------------------------------------
    // parse datapath and decode stage outputs
    // ------------------------------------------------------------------
    always_comb begin
        pixels_left_next = pixels_left_reg;
        current_row_next = current_row_reg;
        screen_col_next  = screen_col_reg;
        column_top_next  = column_top_reg;
        blocked_next     = blocked_reg;
        col_flip_next    = col_flip_reg;
        col_trans_next   = col_trans_reg;
        emit             = 1'b0;
        tbl_we           = 1'b0;
        tbl_re           = 1'b0;
        s1_next          = '0;

        if (s_accept) begin
            priority if (s_mode == MODE_START) begin
                col_flip_next    = flip_reg;
                col_trans_next   = translate_reg;
                pixels_left_next = '0;
                blocked_next     = place_bad;
                if (place_bad) begin
                    // rejected column: one error item, the rest is consumed silently
                    screen_col_next  = '0;
                    column_top_next  = '0;
                    current_row_next = '0;
                    emit             = 1'b1;
                    s1_next.err      = 1'b1;
                end else begin
                    screen_col_next  = flip_reg ? flip_pos[COORD_W-1:0] : col_pos[COORD_W-1:0];
                    column_top_next  = pos_y[COORD_W-1:0];
                    current_row_next = pos_y[COORD_W-1:0];
                end
            end else if (s_mode == MODE_LOAD) begin
                tbl_we = 1'b1;
            end else if (s_mode == MODE_BYTE) begin
                unique case (phase_reg)
                    PH_TOP: begin
                        if (s_byte_value != END_OF_COLUMN) begin
                            current_row_next = column_top_reg + COORD_W'(s_byte_value);
                        end
                    end
                    PH_LEN: pixels_left_next = s_byte_value;
                    PH_PIX: begin
                        current_row_next = current_row_reg + COORD_W'(1);
                        pixels_left_next = pixels_left_reg - 8'd1;
                        // rows below the screen are dropped
                        if (!blocked_reg && (current_row_reg < SH_U)) begin
                            emit            = 1'b1;
                            tbl_re          = 1'b1;
                            s1_next.use_tbl = col_trans_reg && !col_flip_reg;
                            s1_next.row     = current_row_reg;
                            s1_next.col     = screen_col_reg;
                            s1_next.raw     = s_byte_value;
                        end
                    end
                    default: ;
                endcase
            end else begin
                // unused mode, nothing to do
                emit = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg       <= PH_IDLE;
            pixels_left_reg <= '0;
            current_row_reg <= '0;
            screen_col_reg  <= '0;
            column_top_reg  <= '0;
            blocked_reg     <= 1'b0;
            col_flip_reg    <= 1'b0;
            col_trans_reg   <= 1'b0;
        end else begin
            phase_reg       <= phase_next;
            pixels_left_reg <= pixels_left_next;
            current_row_reg <= current_row_next;
            screen_col_reg  <= screen_col_next;
            column_top_reg  <= column_top_next;
            blocked_reg     <= blocked_next;
            col_flip_reg    <= col_flip_next;
            col_trans_reg   <= col_trans_next;
        end
    end

    // ------------------------------------------------------------------
    // colour translation table; read data holds while the decode stage waits
    // ------------------------------------------------------------------
    mcpb_ram #(
        .WIDTH (PIXEL_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .clk   (aclk),
        .we    (tbl_we),
        .waddr (s_table_index),
        .wdata (s_byte_value),
        .re    (tbl_re),
        .raddr (s_byte_value),
        .rdata (tbl_rdata)
    );

    // ------------------------------------------------------------------
    // decode stage register
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (s_ready) begin
            s1_valid_reg <= s_accept && emit;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept && emit) begin
            s1_reg <= s1_next;
        end
    end

    // ------------------------------------------------------------------
    // address multiply-add and output register
    // ------------------------------------------------------------------
    assign addr_full = PROD_W'(s1_reg.row) * PROD_W'(SCREEN_WIDTH) + PROD_W'(s1_reg.col);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s1_adv) begin
            m_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_adv && s1_valid_reg) begin
            m_addr_reg  <= addr_full[ADDR_W-1:0];
            m_pixel_reg <= s1_reg.use_tbl ? tbl_rdata : s1_reg.raw;
            m_err_reg   <= s1_reg.err;
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_fb_address      = m_addr_reg;
    assign m_pixel           = m_pixel_reg;
    assign m_placement_error = m_err_reg;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    `MCPB_ASSERT(a_s1_moves_out, aclk, aresetn, (s1_valid_reg && s1_adv) |=> m_valid_reg, "decoded item lost on its way to the output")
    `MCPB_ASSERT(a_ready_only_full, aclk, aresetn, !s_ready |-> (s1_valid_reg && m_valid_reg && !m_ready), "input stalled while a stage is free")
    `MCPB_ASSERT(a_err_zero, aclk, aresetn, (m_valid_reg && m_err_reg) |-> (m_addr_reg == '0 && m_pixel_reg == '0), "error item carries a nonzero address or pixel")
    `MCPB_ASSERT(a_tbl_hold, aclk, aresetn, (s1_valid_reg && !s1_adv) |=> $stable(tbl_rdata), "table read data changed under a stalled item")
    `MCPB_ASSERT_NEVER(a_rw_clash, aclk, aresetn, tbl_we && tbl_re, "table written and read by one item")

endmodule
